>>> design/atrp_pkg.sv
package atrp_pkg;

  // Payload length limit; the length field also has to fit in 12 bits
  localparam int MAX_PAYLOAD = 2048;
  localparam int LEN_CAP_I   = (MAX_PAYLOAD > 4095) ? 4095 : MAX_PAYLOAD;
  localparam logic [11:0] LEN_CAP = 12'(LEN_CAP_I);

  // Decoupling queue between classifier and parse engine
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // Result event codes
  localparam logic [2:0] EV_PAYLOAD   = 3'd0;
  localparam logic [2:0] EV_OK        = 3'd1;
  localparam logic [2:0] EV_ERROR     = 3'd2;
  localparam logic [2:0] EV_READY     = 3'd3;
  localparam logic [2:0] EV_RESTARTED = 3'd4;
  localparam logic [2:0] EV_SEND_FAIL = 3'd5;
  localparam logic [2:0] EV_HEADER    = 3'd6;

  // Parser modes
  localparam logic [1:0] MODE_LINE = 2'd0;
  localparam logic [1:0] MODE_HDR  = 2'd1;
  localparam logic [1:0] MODE_DATA = 2'd2;

  // Header field indexes
  localparam logic [1:0] FLD_PREFIX = 2'd0;
  localparam logic [1:0] FLD_LENGTH = 2'd1;
  localparam logic [1:0] FLD_ADDR   = 2'd2;
  localparam logic [1:0] FLD_PORT   = 2'd3;

  // Line candidates: header prefix, prompt, ready, OK, SEND OK, ERROR, SEND FAIL
  localparam int NCAND = 7;
  localparam int CAND_HDR    = 0;
  localparam int CAND_PROMPT = 1;
  localparam int CAND_READY  = 2;
  localparam int CAND_OK     = 3;
  localparam int CAND_SENDOK = 4;
  localparam int CAND_ERROR  = 5;
  localparam int CAND_FAIL   = 6;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;

  localparam logic [7:0] CAND_TEXT [NCAND][16] = '{
    '{"+", "I", "P", "D", CH_NUL, CH_NUL, CH_NUL, CH_NUL,
      CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
    '{">", " ", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL,
      CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
    '{"r", "e", "a", "d", "y", CH_CR, CH_LF, CH_NUL,
      CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
    '{"O", "K", CH_CR, CH_LF, CH_NUL, CH_NUL, CH_NUL, CH_NUL,
      CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
    '{"S", "E", "N", "D", " ", "O", "K", CH_CR,
      CH_LF, CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
    '{"E", "R", "R", "O", "R", CH_CR, CH_LF, CH_NUL,
      CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
    '{"S", "E", "N", "D", " ", "F", "A", "I",
      "L", CH_CR, CH_LF, CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL}
  };

  localparam logic [3:0] CAND_LEN [NCAND] = '{
    4'd4, 4'd2, 4'd7, 4'd4, 4'd9, 4'd7, 4'd11
  };

  // One classified received byte
  typedef struct packed {
    logic [7:0] data;
    logic       is_digit;
    logic [3:0] digit;
    logic       is_colon;
    logic       is_comma;
    logic       is_dot;
    logic       is_nl;
  } atrp_item_t;

endpackage

>>> design/at_response_datagram_parser.sv
// Modem response parser, one received byte per transfer.
// Input channel: in_valid / in_ready with in_rx_byte, the raw byte stream
// from the modem serial link. Result channel: out_valid / out_ready with
// one event per transfer: payload byte, ok, error, ready, restarted, send
// failed or datagram header (length, peer address, peer port).
// Bytes that complete nothing (most line text, header text) give no result.
// Throughput: one byte per cycle sustained while results are taken. The
// parse engine updates all of its state for a byte as it consumes it.
// A byte is classified combinationally and stored in a 4-entry queue
// when accepted; once the engine consumes it from the queue head, its
// result, if any, is written into the output register.
// When the receiver stalls, the output register holds its result; the
// engine stops consuming bytes, the queue fills, and in_ready drops once
// the queue is full. in_ready is simply "queue not full".
// Reset (rst_n low, synchronous) empties the queue, drops out_valid and
// returns the parser to line start with no session and no ready seen.
module at_response_datagram_parser
  import atrp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_event_res,
  output logic [7:0]  out_payload_byte,
  output logic        out_last_byte,
  output logic [11:0] out_datagram_length,
  output logic [31:0] out_peer_address,
  output logic [15:0] out_peer_port,
  output logic        out_session_valid
);

  atrp_item_t cls_item;
  atrp_item_t head_item;
  logic       q_full;
  logic       head_valid;
  logic       head_pop;

  assign in_ready = !q_full;

  // Front: byte classification
  atrp_classify u_classify (
    .rx_byte (in_rx_byte),
    .item    (cls_item)
  );

  // Queue between front and engine
  atrp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_valid),
    .push_item  (cls_item),
    .full       (q_full),
    .pop        (head_pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  // Back: parse engine and result register
  atrp_engine u_engine (
    .clk                 (clk),
    .rst_n               (rst_n),
    .item_valid          (head_valid),
    .item                (head_item),
    .item_pop            (head_pop),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_event_res       (out_event_res),
    .out_payload_byte    (out_payload_byte),
    .out_last_byte       (out_last_byte),
    .out_datagram_length (out_datagram_length),
    .out_peer_address    (out_peer_address),
    .out_peer_port       (out_peer_port),
    .out_session_valid   (out_session_valid)
  );

endmodule

>>> design/atrp_classify.sv
module atrp_classify
  import atrp_pkg::*;
(
  input  logic [7:0] rx_byte,
  output atrp_item_t item
);

  logic [7:0] digit_full;

  assign digit_full = rx_byte - 8'h30;

  // Character class flags used by the header parser
  always_comb begin
    item.data     = rx_byte;
    item.is_digit = (rx_byte >= "0") && (rx_byte <= "9");
    item.digit    = digit_full[3:0];
    item.is_colon = (rx_byte == ":");
    item.is_comma = (rx_byte == ",");
    item.is_dot   = (rx_byte == ".");
    item.is_nl    = (rx_byte == CH_LF);
  end

endmodule

>>> design/atrp_queue.sv
module atrp_queue
  import atrp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  atrp_item_t push_item,
  output logic       full,
  input  logic       pop,
  output logic       head_valid,
  output atrp_item_t head_item
);

  atrp_item_t       mem [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0]   count_r, count_nxt;
  logic             do_push, do_pop;

  assign full       = (count_r == QCW'(QDEPTH));
  assign head_valid = (count_r != '0);
  assign head_item  = mem[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

endmodule

>>> design/atrp_engine.sv
module atrp_engine
  import atrp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        item_valid,
  input  atrp_item_t  item,
  output logic        item_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_event_res,
  output logic [7:0]  out_payload_byte,
  output logic        out_last_byte,
  output logic [11:0] out_datagram_length,
  output logic [31:0] out_peer_address,
  output logic [15:0] out_peer_port,
  output logic        out_session_valid
);

  // Parser state
  logic [1:0]       mode_r, mode_nxt;
  logic [NCAND-1:0] cand_r, cand_nxt;
  logic [3:0]       pos_r, pos_nxt;
  logic [1:0]       field_r, field_nxt;
  logic [15:0]      num_r, num_nxt;
  logic [31:0]      addr_r, addr_nxt;
  logic [11:0]      remain_r, remain_nxt;
  logic             ready_seen_r, ready_seen_nxt;
  logic [31:0]      sess_addr_r, sess_addr_nxt;
  logic [15:0]      sess_port_r, sess_port_nxt;
  logic             sess_flag_r, sess_flag_nxt;

  // Output register
  logic             ovalid_r, ovalid_nxt;
  logic [2:0]       oev_r, oev_nxt;
  logic [7:0]       opay_r, opay_nxt;
  logic             olast_r, olast_nxt;
  logic [11:0]      olen_r, olen_nxt;
  logic [31:0]      oaddr_r, oaddr_nxt;
  logic [15:0]      oport_r, oport_nxt;
  logic             osess_r, osess_nxt;

  logic             take;
  logic             emit;
  logic [2:0]       ev;
  logic [NCAND-1:0] live;
  logic [3:0]       pos_inc;
  logic [19:0]      acc_wide;
  logic [19:0]      acc_cap;
  logic [31:0]      addr_shift;
  logic [11:0]      hdr_len;
  logic [31:0]      hdr_addr;
  logic [15:0]      hdr_port;
  logic [11:0]      remain_dec;

  assign take     = item_valid && (!ovalid_r || out_ready);
  assign item_pop = take;

  // Candidate match for the current line position
  always_comb begin
    for (int k = 0; k < NCAND; k++) begin
      live[k] = cand_r[k] && (pos_r < CAND_LEN[k]) && (CAND_TEXT[k][pos_r] == item.data);
    end
    pos_inc = (pos_r != 4'hF) ? pos_r + 4'd1 : pos_r;
  end

  // Decimal accumulate with per-field saturation
  always_comb begin
    acc_wide = ({4'b0, num_r} << 3) + ({4'b0, num_r} << 1) + {16'b0, item.digit};
    case (field_r)
      FLD_LENGTH: acc_cap = {8'b0, LEN_CAP};
      FLD_ADDR:   acc_cap = 20'd255;
      default:    acc_cap = 20'd65535;
    endcase
  end

  // Values that closing the header produces
  always_comb begin
    addr_shift = {addr_r[23:0], num_r[7:0]};
    hdr_len    = (field_r == FLD_LENGTH) ? num_r[11:0] : remain_r;
    hdr_addr   = (field_r == FLD_ADDR) ? addr_shift : addr_r;
    hdr_port   = (field_r == FLD_PORT) ? num_r : 16'd0;
    remain_dec = (remain_r != '0) ? remain_r - 12'd1 : remain_r;
  end

  // Per-byte parser step
  always_comb begin
    mode_nxt       = mode_r;
    cand_nxt       = cand_r;
    pos_nxt        = pos_r;
    field_nxt      = field_r;
    num_nxt        = num_r;
    addr_nxt       = addr_r;
    remain_nxt     = remain_r;
    ready_seen_nxt = ready_seen_r;
    sess_addr_nxt  = sess_addr_r;
    sess_port_nxt  = sess_port_r;
    sess_flag_nxt  = sess_flag_r;
    emit           = 1'b0;
    ev             = EV_OK;
    opay_nxt       = 8'd0;
    olast_nxt      = 1'b0;
    olen_nxt       = 12'd0;
    oaddr_nxt      = 32'd0;
    oport_nxt      = 16'd0;

    case (mode_r)
      MODE_HDR: begin
        if (item.is_colon) begin
          remain_nxt    = hdr_len;
          addr_nxt      = hdr_addr;
          sess_addr_nxt = hdr_addr;
          sess_port_nxt = hdr_port;
          sess_flag_nxt = 1'b1;
          mode_nxt      = (hdr_len != '0) ? MODE_DATA : MODE_LINE;
          pos_nxt       = '0;
          cand_nxt      = '1;
          emit          = 1'b1;
          ev            = EV_HEADER;
          olast_nxt     = (hdr_len == '0);
          olen_nxt      = hdr_len;
          oaddr_nxt     = hdr_addr;
          oport_nxt     = hdr_port;
        end else if (item.is_comma) begin
          if (field_r != FLD_PORT) begin
            if (field_r == FLD_LENGTH) begin
              remain_nxt = num_r[11:0];
            end else if (field_r == FLD_ADDR) begin
              addr_nxt = addr_shift;
            end
            field_nxt = field_r + 2'd1;
            num_nxt   = '0;
          end
        end else if ((field_r == FLD_ADDR) && item.is_dot) begin
          addr_nxt = addr_shift;
          num_nxt  = '0;
        end else if (item.is_digit && (field_r != FLD_PREFIX)) begin
          num_nxt = (acc_wide > acc_cap) ? acc_cap[15:0] : acc_wide[15:0];
        end
      end

      MODE_DATA: begin
        remain_nxt = remain_dec;
        if (remain_dec == '0) begin
          mode_nxt = MODE_LINE;
          pos_nxt  = '0;
          cand_nxt = '1;
        end
        emit      = 1'b1;
        ev        = EV_PAYLOAD;
        opay_nxt  = item.data;
        olast_nxt = (remain_dec == '0);
      end

      default: begin
        if (live[CAND_HDR] && (pos_inc == 4'd4)) begin
          mode_nxt   = MODE_HDR;
          field_nxt  = FLD_PREFIX;
          num_nxt    = '0;
          addr_nxt   = '0;
          remain_nxt = '0;
          pos_nxt    = '0;
          cand_nxt   = '1;
        end else if (live[CAND_PROMPT] && (pos_inc == 4'd2)) begin
          pos_nxt  = '0;
          cand_nxt = '1;
          emit     = 1'b1;
          ev       = EV_OK;
        end else if (item.is_nl) begin
          pos_nxt  = '0;
          cand_nxt = '1;
          if (live[CAND_READY]) begin
            emit           = 1'b1;
            ev             = ready_seen_r ? EV_RESTARTED : EV_READY;
            ready_seen_nxt = 1'b1;
          end else if (live[CAND_OK] || live[CAND_SENDOK]) begin
            emit = 1'b1;
            ev   = EV_OK;
          end else if (live[CAND_ERROR]) begin
            emit = 1'b1;
            ev   = EV_ERROR;
          end else if (live[CAND_FAIL]) begin
            emit          = 1'b1;
            ev            = EV_SEND_FAIL;
            sess_addr_nxt = '0;
            sess_port_nxt = '0;
            sess_flag_nxt = 1'b0;
          end
        end else begin
          pos_nxt  = pos_inc;
          cand_nxt = live;
        end
      end
    endcase

    oev_nxt    = ev;
    osess_nxt  = sess_flag_nxt;
    ovalid_nxt = take ? emit : (ovalid_r && !out_ready);
  end

  // State registers advance only on a consumed byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_LINE;
      cand_r       <= '1;
      pos_r        <= '0;
      field_r      <= FLD_PREFIX;
      num_r        <= '0;
      addr_r       <= '0;
      remain_r     <= '0;
      ready_seen_r <= 1'b0;
      sess_addr_r  <= '0;
      sess_port_r  <= '0;
      sess_flag_r  <= 1'b0;
      ovalid_r     <= 1'b0;
    end else begin
      ovalid_r <= ovalid_nxt;
      if (take) begin
        mode_r       <= mode_nxt;
        cand_r       <= cand_nxt;
        pos_r        <= pos_nxt;
        field_r      <= field_nxt;
        num_r        <= num_nxt;
        addr_r       <= addr_nxt;
        remain_r     <= remain_nxt;
        ready_seen_r <= ready_seen_nxt;
        sess_addr_r  <= sess_addr_nxt;
        sess_port_r  <= sess_port_nxt;
        sess_flag_r  <= sess_flag_nxt;
      end
    end
  end

  // Result payload register
  always_ff @(posedge clk) begin
    if (take && emit) begin
      oev_r   <= oev_nxt;
      opay_r  <= opay_nxt;
      olast_r <= olast_nxt;
      olen_r  <= olen_nxt;
      oaddr_r <= oaddr_nxt;
      oport_r <= oport_nxt;
      osess_r <= osess_nxt;
    end
  end

  assign out_valid           = ovalid_r;
  assign out_event_res       = oev_r;
  assign out_payload_byte    = opay_r;
  assign out_last_byte       = olast_r;
  assign out_datagram_length = olen_r;
  assign out_peer_address    = oaddr_r;
  assign out_peer_port       = oport_r;
  assign out_session_valid   = osess_r;

endmodule

>>> design/atrp_checker.sv
module atrp_checker
  import atrp_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_event_res,
  input logic [7:0]  out_payload_byte,
  input logic        out_last_byte,
  input logic [11:0] out_datagram_length,
  input logic [31:0] out_peer_address,
  input logic [15:0] out_peer_port,
  input logic        out_session_valid
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_event_res)
      && $stable(out_payload_byte) && $stable(out_last_byte))
    else $error("result changed while stalled");

  // Header results always open a session
  a_hdr_session: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_res == EV_HEADER) |-> out_session_valid)
    else $error("header without session");

  // Send failure always closes the session
  a_fail_session: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_res == EV_SEND_FAIL) |-> !out_session_valid)
    else $error("send failure left session open");

  // Header fields are zero outside header results
  a_hdr_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_res != EV_HEADER)
      |-> (out_datagram_length == '0) && (out_peer_address == '0) && (out_peer_port == '0))
    else $error("header fields set on non-header result");

  // Payload byte and last flag only on payload results, except an empty header
  a_pay_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_res != EV_PAYLOAD)
      |-> (out_payload_byte == '0)
        && (!out_last_byte || ((out_event_res == EV_HEADER) && (out_datagram_length == '0))))
    else $error("payload fields set on non-payload result");

endmodule

bind at_response_datagram_parser atrp_checker u_atrp_checker (.*);
